// File: hw/rtl/nnu_pkg.sv
// ----------------------------------------------------------------------------
// nnu_pkg: shared definitions for the nearest-neighbor upscaler
// Field widths, register indexes, request kinds, the queue entry and the
// divider request/response structs, and the size helper functions.
// ----------------------------------------------------------------------------
package nnu_pkg;

	localparam int COLOR_W           = 32;
	localparam int POS_W             = 12;
	localparam int DIM_W             = 13;
	localparam int PROD_W            = 2 * DIM_W;
	localparam int MAX_DIM           = 4096;
	localparam int SOURCE_PIXELS_DEF = 65536;
	localparam int CFG_IDX_W         = 3;
	localparam int QUEUE_DEPTH       = 4;
	localparam int TDATA_W           = 88;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POW2_MODE   = 3'd4;

	// request kinds
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef struct packed {
		logic               op;
		logic [COLOR_W-1:0] color;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] src_height;
		logic [DIM_W-1:0] disp_width;
		logic [DIM_W-1:0] disp_height;
		logic             pow2_mode;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [DIM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
		logic [DIM_W-1:0]  rem;
	} div_rsp_t;

	// zero reads as one, anything above MAX_DIM as MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	// smallest power of two not below v (v is at least one)
	function automatic logic [DIM_W:0] round_pow2(input logic [DIM_W-1:0] v);
		logic [DIM_W:0] p;
		logic           found;
		p = '0;
		found = 1'b0;
		for (int i = 0; i <= DIM_W; i++) begin
			if (!found && (((DIM_W + 1)'(1) << i) >= {1'b0, v})) begin
				p = (DIM_W + 1)'(1) << i;
				found = 1'b1;
			end
		end
		return p;
	endfunction

endpackage

// File: hw/rtl/nnu_front.sv
// ----------------------------------------------------------------------------
// nnu_front: request intake
// Registers each incoming request, tags it as a pixel load or an output
// pixel request and hands it to the request queue.
// ----------------------------------------------------------------------------
module nnu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [nnu_pkg::COLOR_W-1:0]  s_tdata,   // [31:0] pixel_color
	input  logic                         s_tuser,   // [0] req_type
	output logic                         push,
	output nnu_pkg::item_t               push_item,
	input  logic                         full
);
	import nnu_pkg::*;

	logic  hold_valid_q;
	item_t hold_item_q;

	assign s_tready  = !hold_valid_q || !full;
	assign push      = hold_valid_q && !full;
	assign push_item = hold_item_q;

	// holding stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			hold_valid_q <= 1'b1;
		end else if (!full) begin
			hold_valid_q <= 1'b0;
		end
	end

	// classify: output requests carry no color
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hold_item_q.op    <= s_tuser ? OP_EMIT : OP_LOAD;
			hold_item_q.color <= s_tuser ? '0 : s_tdata;
		end
	end

endmodule

// File: hw/rtl/nnu_queue.sv
// ----------------------------------------------------------------------------
// nnu_queue: request queue
// Short FIFO between intake and execution so either side can stall alone.
// ----------------------------------------------------------------------------
module nnu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nnu_pkg::item_t push_item,
	output logic           full,
	output logic           head_valid,
	output nnu_pkg::item_t head_item,
	input  logic           pop
);
	import nnu_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/nnu_div.sv
// ----------------------------------------------------------------------------
// nnu_div: serial divider
// Restoring division, one quotient bit per cycle.
// The remainder stays below the divisor, so it needs only DIM_W bits.
// ----------------------------------------------------------------------------
module nnu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  nnu_pkg::div_req_t req,
	output nnu_pkg::div_rsp_t rsp
);
	import nnu_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);

	logic [PROD_W-1:0] quo_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIM_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? DIM_W'(trial - {1'b0, dvs_q}) : trial[DIM_W-1:0];
		end
	end

endmodule

// File: hw/rtl/nnu_back.sv
// ----------------------------------------------------------------------------
// nnu_back: request execution
// Size setup sequencer, output position stepping with remainder
// accumulators, index multiply, frame store and the output register.
// ----------------------------------------------------------------------------
module nnu_back #(
	parameter int SOURCE_PIXELS = nnu_pkg::SOURCE_PIXELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nnu_pkg::cfg_t                cfg,
	input  logic                         cfg_we,
	input  logic                         head_valid,
	input  nnu_pkg::item_t               head_item,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] out_color, [43:32] out_x, [55:44] out_y,
	// [68:56] target_cols, [81:69] target_rows, [87:82] zero
	output logic [nnu_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tlast,   // frame_last
	output logic                         m_tuser    // [0] pow2_chosen
);
	import nnu_pkg::*;

	localparam int AW    = (SOURCE_PIXELS > 1) ? $clog2(SOURCE_PIXELS) : 1;
	localparam int LCW   = $clog2(SOURCE_PIXELS + 1);
	localparam int CW    = (PROD_W > LCW) ? PROD_W : LCW;
	localparam int PAD_W = TDATA_W - COLOR_W - 2 * POS_W - 2 * DIM_W;
	localparam int AREA_W = PROD_W + 2;

	localparam logic [2:0] ST_RUN      = 3'd0;
	localparam logic [2:0] ST_CLAMP    = 3'd1;
	localparam logic [2:0] ST_AREA     = 3'd2;
	localparam logic [2:0] ST_PICK     = 3'd3;
	localparam logic [2:0] ST_FIX      = 3'd4;
	localparam logic [2:0] ST_DIV_GO   = 3'd5;
	localparam logic [2:0] ST_DIV_WAIT = 3'd6;

	localparam logic [1:0] JOB_X_POS  = 2'd0;
	localparam logic [1:0] JOB_X_STEP = 2'd1;
	localparam logic [1:0] JOB_Y_POS  = 2'd2;
	localparam logic [1:0] JOB_Y_STEP = 2'd3;

	// setup control
	logic [2:0]         state_q;
	logic [1:0]         job_q;
	logic               dirty_q;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// sizes
	logic [DIM_W-1:0]   sw_q, sh_q, dw_q, dh_q;
	logic [DIM_W:0]     pw_q, ph_q;
	logic [AREA_W-1:0]  area_p_q, area_d_q;
	logic [DIM_W-1:0]   tw_q, th_q;
	logic               p2_q;
	logic [PROD_W-1:0]  prodx_q, prody_q;

	// position and source coordinate accumulators
	logic [DIM_W-1:0]   col_q, row_q;
	logic [DIM_W-1:0]   sx_q, rx_q, sy_q, ry_q;
	logic [DIM_W-1:0]   qx_q, stx_q, qy_q, sty_q;
	logic [LCW-1:0]     load_count_q;

	// pipeline
	logic               v_s1, v_s2, v_s3;
	logic               op_s1, op_s2;
	logic [COLOR_W-1:0] color_s1, color_s2;
	logic [DIM_W-1:0]   x_s1, x_s2, x_s3, y_s1, y_s2, y_s3;
	logic [DIM_W-1:0]   sx_s1, sx_s2, sy_s1;
	logic               last_s1, last_s2, last_s3;
	logic [DIM_W-1:0]   tw_s1, tw_s2, tw_s3, th_s1, th_s2, th_s3;
	logic               p2_s1, p2_s2, p2_s3;
	logic [PROD_W-1:0]  prod_s2;
	logic               hit_s3;
	logic [COLOR_W-1:0] rdata_q;
	logic [COLOR_W-1:0] store_mem [SOURCE_PIXELS];

	// combinational
	logic               adv, head_emit, emit_go, restart;
	logic               col_end, row_end, last0;
	logic [DIM_W:0]     sum_x, sum_y;
	logic               wrap_x, wrap_y;
	logic [PROD_W-1:0]  idx_s2;
	logic               hit, lc_full, mem_we, mem_re;
	logic [COLOR_W-1:0] color_out;

	nnu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign adv       = !v_s3 || m_tready;
	assign head_emit = head_item.op == OP_EMIT;
	assign pop       = (state_q == ST_RUN) && head_valid && adv && (!head_emit || !dirty_q);
	assign emit_go   = pop && head_emit;
	assign restart   = (col_q >= tw_q) || (row_q >= th_q);

	// end-of-line / end-of-frame detection
	assign col_end = col_q == (tw_q - DIM_W'(1));
	assign row_end = row_q == (th_q - DIM_W'(1));
	assign last0   = col_end && row_end;

	// remainder steps: one compare and subtract each
	assign sum_x  = {1'b0, rx_q} + {1'b0, stx_q};
	assign sum_y  = {1'b0, ry_q} + {1'b0, sty_q};
	assign wrap_x = sum_x >= {1'b0, tw_q};
	assign wrap_y = sum_y >= {1'b0, th_q};

	// store access stage
	assign idx_s2  = prod_s2 + PROD_W'(sx_s2);
	assign hit     = CW'(idx_s2) < CW'(load_count_q);
	assign lc_full = load_count_q == LCW'(SOURCE_PIXELS);
	assign mem_we  = adv && v_s2 && (op_s2 == OP_LOAD) && !lc_full;
	assign mem_re  = adv && v_s2 && (op_s2 == OP_EMIT) && hit;

	// divider job select
	always_comb begin
		div_req.start = state_q == ST_DIV_GO;
		case (job_q)
			JOB_X_POS: begin
				div_req.dividend = prodx_q;
				div_req.divisor  = tw_q;
			end
			JOB_X_STEP: begin
				div_req.dividend = PROD_W'(sw_q);
				div_req.divisor  = tw_q;
			end
			JOB_Y_POS: begin
				div_req.dividend = prody_q;
				div_req.divisor  = th_q;
			end
			default: begin
				div_req.dividend = PROD_W'(sh_q);
				div_req.divisor  = th_q;
			end
		endcase
	end

	// any register write forces a new size setup; a finished setup clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b1;
		end else if (cfg_we) begin
			dirty_q <= 1'b1;
		end else if ((state_q == ST_DIV_WAIT) && div_rsp.done && (job_q == JOB_Y_STEP)) begin
			dirty_q <= 1'b0;
		end
	end

	// setup sequencer, position state, stage valids, load count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			job_q        <= JOB_X_POS;
			col_q        <= '0;
			row_q        <= '0;
			sx_q         <= '0;
			rx_q         <= '0;
			sy_q         <= '0;
			ry_q         <= '0;
			load_count_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (head_valid && head_emit && dirty_q) begin
						state_q <= ST_CLAMP;
						job_q   <= JOB_X_POS;
					end
					if (emit_go) begin
						if (last0) begin
							col_q <= '0;
							row_q <= '0;
							sx_q  <= '0;
							rx_q  <= '0;
							sy_q  <= '0;
							ry_q  <= '0;
						end else if (col_end) begin
							col_q <= '0;
							sx_q  <= '0;
							rx_q  <= '0;
							row_q <= row_q + DIM_W'(1);
							sy_q  <= sy_q + qy_q + DIM_W'(wrap_y);
							ry_q  <= wrap_y ? DIM_W'(sum_y - {1'b0, th_q}) : sum_y[DIM_W-1:0];
						end else begin
							col_q <= col_q + DIM_W'(1);
							sx_q  <= sx_q + qx_q + DIM_W'(wrap_x);
							rx_q  <= wrap_x ? DIM_W'(sum_x - {1'b0, tw_q}) : sum_x[DIM_W-1:0];
						end
					end
				end
				ST_CLAMP: state_q <= ST_AREA;
				ST_AREA:  state_q <= ST_PICK;
				ST_PICK:  state_q <= ST_FIX;
				ST_FIX: begin
					if (restart) begin
						col_q <= '0;
						row_q <= '0;
					end
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (job_q == JOB_X_POS) begin
							sx_q <= div_rsp.quot[DIM_W-1:0];
							rx_q <= div_rsp.rem;
						end
						if (job_q == JOB_Y_POS) begin
							sy_q <= div_rsp.quot[DIM_W-1:0];
							ry_q <= div_rsp.rem;
						end
						if (job_q == JOB_Y_STEP) begin
							state_q <= ST_RUN;
						end else begin
							job_q   <= job_q + 2'd1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase

			if (adv) begin
				v_s1 <= pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2 && (op_s2 == OP_EMIT);
			end

			// load count follows store order; a finished frame reloads afresh
			if (adv && v_s2) begin
				if (op_s2 == OP_LOAD) begin
					if (!lc_full) begin
						load_count_q <= load_count_q + LCW'(1);
					end
				end else if (last_s2) begin
					load_count_q <= '0;
				end
			end
		end
	end

	// setup datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLAMP: begin
				sw_q <= clamp_dim(cfg.src_width);
				sh_q <= clamp_dim(cfg.src_height);
				dw_q <= clamp_dim(cfg.disp_width);
				dh_q <= clamp_dim(cfg.disp_height);
				pw_q <= round_pow2(clamp_dim(cfg.src_width));
				ph_q <= round_pow2(clamp_dim(cfg.src_height));
			end
			ST_AREA: begin
				area_p_q <= AREA_W'(pw_q) * AREA_W'(ph_q);
				area_d_q <= AREA_W'(dw_q) * AREA_W'(dh_q);
			end
			ST_PICK: begin
				if ((dw_q <= sw_q) && (dh_q <= sh_q)) begin
					tw_q <= sw_q;
					th_q <= sh_q;
					p2_q <= 1'b0;
				end else if (cfg.pow2_mode && (area_p_q < area_d_q)) begin
					tw_q <= pw_q[DIM_W-1:0];
					th_q <= ph_q[DIM_W-1:0];
					p2_q <= 1'b1;
				end else begin
					tw_q <= dw_q;
					th_q <= dh_q;
					p2_q <= 1'b0;
				end
			end
			ST_FIX: begin
				prodx_q <= restart ? '0 : PROD_W'(col_q) * PROD_W'(sw_q);
				prody_q <= restart ? '0 : PROD_W'(row_q) * PROD_W'(sh_q);
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done && (job_q == JOB_X_STEP)) begin
					qx_q  <= div_rsp.quot[DIM_W-1:0];
					stx_q <= div_rsp.rem;
				end
				if (div_rsp.done && (job_q == JOB_Y_STEP)) begin
					qy_q  <= div_rsp.quot[DIM_W-1:0];
					sty_q <= div_rsp.rem;
				end
			end
			default: begin
			end
		endcase
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= head_item.op;
			color_s1 <= head_item.color;
			x_s1     <= col_q;
			y_s1     <= row_q;
			sx_s1    <= sx_q;
			sy_s1    <= sy_q;
			last_s1  <= last0;
			tw_s1    <= tw_q;
			th_s1    <= th_q;
			p2_s1    <= p2_q;

			op_s2    <= op_s1;
			color_s2 <= color_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			sx_s2    <= sx_s1;
			last_s2  <= last_s1;
			tw_s2    <= tw_s1;
			th_s2    <= th_s1;
			p2_s2    <= p2_s1;
			prod_s2  <= PROD_W'(sy_s1) * PROD_W'(sw_q);

			x_s3     <= x_s2;
			y_s3     <= y_s2;
			last_s3  <= last_s2;
			tw_s3    <= tw_s2;
			th_s3    <= th_s2;
			p2_s3    <= p2_s2;
			hit_s3   <= hit;
		end
	end

	// frame store: loads and reads meet here in request order
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[load_count_q[AW-1:0]] <= color_s2;
		end
		if (mem_re) begin
			rdata_q <= store_mem[idx_s2[AW-1:0]];
		end
	end

	// output register
	assign color_out = hit_s3 ? rdata_q : '0;
	assign m_tvalid  = v_s3;
	assign m_tdata   = {{PAD_W{1'b0}}, th_s3, tw_s3, y_s3[POS_W-1:0], x_s3[POS_W-1:0],
		color_out};
	assign m_tlast   = last_s3;
	assign m_tuser   = p2_s3;

endmodule

// File: hw/rtl/nearest_neighbor_image_upscaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_upscaler: nearest-neighbor image upscaler top level
// Loads RGBA source pixels into a frame store and streams out the enlarged
// image in raster order.
// Usage: s_* carries requests: tuser low loads tdata as the next source pixel,
//   tuser high requests the next output pixel, answered by one pixel on m_*
//   with its position and the chosen target size; tlast marks the final pixel
//   of the frame, after which loading starts afresh. cfg_we/cfg_index/cfg_data
//   write the size registers while idle.
// Timing: one request per cycle while the queue has room. A result passes
//   through the intake register, queue, issue stage, multiply stage and
//   store read into the output register before it shows on m_*. After reset
//   or any register write the first output request waits for the size setup:
//   noticing the write, size selection and four serial divisions in the
//   shared divider.
// Reset: position, load count and registers return to their reset values;
//   the frame store is not cleared, only loaded entries are ever read.
// Stall: while m_tready is low the execution side holds; requests keep being
//   accepted until the queue and intake register are full.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_upscaler #(
	parameter int SOURCE_PIXELS = nnu_pkg::SOURCE_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nnu_pkg::COLOR_W-1:0]   s_tdata,    // [31:0] pixel_color
	input  logic                          s_tuser,    // [0] req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] out_color, [43:32] out_x, [55:44] out_y,
	// [68:56] target_cols, [81:69] target_rows, [87:82] zero
	output logic [nnu_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tlast,    // frame_last
	output logic                          m_tuser,    // [0] pow2_chosen
	input  logic                          cfg_we,
	input  logic [nnu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnu_pkg::DIM_W-1:0]     cfg_data
);
	import nnu_pkg::*;

	cfg_t  cfg_q;
	logic  q_push;
	item_t q_push_item;
	logic  q_full;
	logic  q_head_valid;
	item_t q_head_item;
	logic  q_pop;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width   <= DIM_W'(1);
			cfg_q.src_height  <= DIM_W'(1);
			cfg_q.disp_width  <= DIM_W'(1);
			cfg_q.disp_height <= DIM_W'(1);
			cfg_q.pow2_mode   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data;
				REG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data;
				REG_DISP_WIDTH:  cfg_q.disp_width  <= cfg_data;
				REG_DISP_HEIGHT: cfg_q.disp_height <= cfg_data;
				REG_POW2_MODE:   cfg_q.pow2_mode   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	nnu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full)
	);

	nnu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_item  (q_head_item),
		.pop        (q_pop)
	);

	nnu_back #(
		.SOURCE_PIXELS (SOURCE_PIXELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cfg_we     (cfg_we),
		.head_valid (q_head_valid),
		.head_item  (q_head_item),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

// File: hw/rtl/nnu_checker.sv
// ----------------------------------------------------------------------------
// nnu_checker: output stream checks
// Watches the output port of the upscaler: stall behavior, positions inside
// the target frame, frame end at the last position, power-of-two sizes.
// ----------------------------------------------------------------------------
module nnu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [nnu_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tlast,
	input logic                        m_tuser
);
	import nnu_pkg::*;

	logic [DIM_W-1:0] x_ext, y_ext, cols, rows;

	assign x_ext = DIM_W'(m_tdata[43:32]);
	assign y_ext = DIM_W'(m_tdata[55:44]);
	assign cols  = m_tdata[68:56];
	assign rows  = m_tdata[81:69];

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed while stalled");

	// position lies inside the reported target size
	a_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (x_ext < cols) && (y_ext < rows))
		else $error("pixel position outside target frame");

	// frame end only at the bottom-right pixel
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (x_ext + DIM_W'(1) == cols) && (y_ext + DIM_W'(1) == rows))
		else $error("frame end flagged away from last pixel");

	// power-of-two choice gives power-of-two sizes
	a_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $onehot(cols) && $onehot(rows))
		else $error("power-of-two size flagged on other size");

endmodule

bind nearest_neighbor_image_upscaler nnu_checker u_nnu_checker (.*);
